FILE: hw/rtl/five_level_page_table_walker_macros.svh
// Assertion macros used by the page table walker top module.
`ifndef FIVE_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH
`define FIVE_LEVEL_PAGE_TABLE_WALKER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTW_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ptw_pkg.sv
package ptw_pkg;

    localparam int LEVELS      = 5;
    localparam int INDEX_BITS  = 9;
    localparam int NODE_FRAMES = 64;

    localparam int FRAME_W     = $clog2(NODE_FRAMES);
    localparam int STORE_AW    = FRAME_W + INDEX_BITS;
    localparam int STORE_DEPTH = NODE_FRAMES << INDEX_BITS;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int FREE_W      = $clog2(NODE_FRAMES + 1);

    localparam int VPN_W   = 45;
    localparam int PPN_W   = 52;
    localparam int ENTRY_W = PPN_W + 1;
    localparam int ROOT_W  = 6;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_FRAME = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 1'd1;

    localparam logic [FREE_W-1:0] FIRST_FREE_RESET = FREE_W'(1);
    localparam logic [LVL_W-1:0]  LAST_LEVEL       = LVL_W'(LEVELS - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_ALLOC,
        ST_LEAF,
        ST_FINISH
    } t_ptw_state;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CLEAR,
        WR_UNMAP,
        WR_LEAF,
        WR_LINK
    } t_wr_sel;

    typedef struct packed {
        logic    ready;
        logic    clr_step;
        logic    rd;
        logic    step_down;
        logic    set_result;
        logic    alloc_step;
        logic    push_out;
        t_wr_sel wr_sel;
    } t_ptw_cmd;

    typedef struct packed {
        logic clr_done;
        logic item_in;
        logic entry_valid;
        logic last_level;
        logic is_update;
        logic is_erase;
        logic fits;
        logic alloc_last;
        logic out_busy;
    } t_ptw_status;

    // Index of one level, top level first.
    function automatic logic [INDEX_BITS-1:0] level_index(
        input logic [VPN_W-1:0] vpn,
        input logic [LVL_W-1:0] lvl
    );
        logic [INDEX_BITS-1:0] res;
        res = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (lvl == LVL_W'(i)) begin
                res = vpn[INDEX_BITS*(LEVELS-1-i) +: INDEX_BITS];
            end
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/five_level_page_table_walker.sv
// Five-level radix page table walker over a local store of 64 nodes of
// 512 entries (53-bit entries: valid in bit 0, frame number above it).
// Each request is a query (command 0) or an update (command 1: map to
// ppn, or unmap when erase is set); each request returns exactly one
// response with found, ppn_out (zero unless found) and out_of_frames.
// After reset the store is swept to zero one entry per cycle, with
// o_stall held high; configuration writes are taken during the sweep.
// One request is in the walker at a time. A request passes an accept
// step, then for each level visited a store read issue and an evaluate
// of the registered read data, then one allocation step per inner node
// allocated plus a leaf write when a map builds a path, and last a step
// that hands the response to the output register. A map that misses at
// the root builds all four inner nodes. The output register lets a
// response wait while the next request is accepted.
// Register 0 sets the root frame; register 1 loads the frame allocator.
module five_level_page_table_walker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_command,
    input  logic [ptw_pkg::VPN_W-1:0]     i_vpn,
    input  logic                          i_erase,
    input  logic [ptw_pkg::PPN_W-1:0]     i_ppn,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ptw_pkg::PPN_W-1:0]     o_ppn_out,
    output logic                          o_out_of_frames
);
    import ptw_pkg::*;

`include "five_level_page_table_walker_macros.svh"

    t_ptw_cmd    cmd;
    t_ptw_status status;

    // Controller sequences the walk; datapath owns the store and registers.
    ptw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_status(status),
        .o_cmd   (cmd)
    );

    ptw_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .i_command      (i_command),
        .i_vpn          (i_vpn),
        .i_erase        (i_erase),
        .i_ppn          (i_ppn),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_ppn_out      (o_ppn_out),
        .o_out_of_frames(o_out_of_frames)
    );

    // Hold off new requests whenever the controller is not idle.
    assign o_stall = !cmd.ready;

    // A request just taken occupies the walker on the next cycle.
    `PTW_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall,
        "walker took a request and did not go busy")
    // A response that missed carries a zero frame number.
    `PTW_ASSERT_SAME(a_miss_zero_ppn, i_clk, i_rst_n, o_valid && !o_found,
        o_ppn_out == '0, "response without a mapping carries a frame number")
    // Running out of frames is only reported for a path that was missing.
    `PTW_ASSERT_SAME(a_oof_not_found, i_clk, i_rst_n, o_valid && o_out_of_frames,
        !o_found, "out of frames reported on a found leaf")

endmodule

FILE: hw/rtl/ptw_ram.sv
module ptw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/ptw_datapath.sv
module ptw_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptw_pkg::t_ptw_cmd             i_cmd,
    output ptw_pkg::t_ptw_status          o_status,
    input  logic                          i_cfg_wr_en,
    input  logic [ptw_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ptw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_valid,
    input  logic                          i_command,
    input  logic [ptw_pkg::VPN_W-1:0]     i_vpn,
    input  logic                          i_erase,
    input  logic [ptw_pkg::PPN_W-1:0]     i_ppn,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ptw_pkg::PPN_W-1:0]     o_ppn_out,
    output logic                          o_out_of_frames
);
    import ptw_pkg::*;

    logic [ROOT_W-1:0]   r_root;
    logic [FREE_W-1:0]   r_next_free;
    logic [STORE_AW-1:0] r_clr_addr;

    logic                r_update;
    logic                r_erase;
    logic [VPN_W-1:0]    r_vpn;
    logic [PPN_W-1:0]    r_ppn;
    logic [FRAME_W-1:0]  r_frame;
    logic [LVL_W-1:0]    r_lvl;
    logic [STORE_AW-1:0] r_addr;

    logic                r_found;
    logic [PPN_W-1:0]    r_ppn_res;
    logic                r_oof;

    logic                r_out_valid;
    logic                r_out_found;
    logic [PPN_W-1:0]    r_out_ppn;
    logic                r_out_oof;

    logic                ram_we;
    logic [STORE_AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0]  ram_wdata;
    logic [STORE_AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    logic [LVL_W-1:0]    n_lvl;
    logic [FREE_W:0]     need_sum;
    logic                out_take;

    assign n_lvl     = r_lvl + LVL_W'(1);
    assign ram_raddr = {r_frame, level_index(r_vpn, r_lvl)};
    assign need_sum  = {1'b0, r_next_free} + (FREE_W + 1)'(LAST_LEVEL - r_lvl);
    assign out_take  = r_out_valid && !i_stall;

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = r_addr;
        ram_wdata = '0;
        case (i_cmd.wr_sel)
            WR_NONE:  ram_we    = 1'b0;
            WR_CLEAR: ram_waddr = r_clr_addr;
            WR_UNMAP: ram_wdata = {ram_rdata[ENTRY_W-1:1], 1'b0};
            WR_LEAF:  ram_wdata = {r_ppn, 1'b1};
            WR_LINK:  ram_wdata = {(PPN_W)'(r_next_free), 1'b1};
            default:  ram_we    = 1'b0;
        endcase
    end

    ptw_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_status.clr_done    = &r_clr_addr;
        o_status.item_in     = i_cmd.ready && i_valid;
        o_status.entry_valid = ram_rdata[0];
        o_status.last_level  = (r_lvl == LAST_LEVEL);
        o_status.is_update   = r_update;
        o_status.is_erase    = r_erase;
        o_status.fits        = (need_sum <= (FREE_W + 1)'(NODE_FRAMES));
        o_status.alloc_last  = (n_lvl == LAST_LEVEL);
        o_status.out_busy    = r_out_valid && i_stall;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_next_free <= FIRST_FREE_RESET;
            r_clr_addr  <= '0;
            r_lvl       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + STORE_AW'(1);
            end
            if (o_status.item_in) begin
                r_lvl <= '0;
            end else if (i_cmd.step_down || i_cmd.alloc_step) begin
                r_lvl <= n_lvl;
            end
            if (i_cmd.alloc_step) begin
                r_next_free <= r_next_free + FREE_W'(1);
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ROOT_FRAME: r_root      <= i_cfg_data[ROOT_W-1:0];
                    CFG_FIRST_FREE: r_next_free <= i_cfg_data[FREE_W-1:0];
                    default:        r_root      <= r_root;
                endcase
            end
            if (i_cmd.push_out) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_status.item_in) begin
            r_update <= i_command;
            r_erase  <= i_erase;
            r_vpn    <= i_vpn;
            r_ppn    <= i_ppn;
            r_frame  <= r_root[FRAME_W-1:0];
        end else if (i_cmd.step_down) begin
            r_frame <= ram_rdata[FRAME_W:1];
        end
        if (i_cmd.rd) begin
            r_addr <= ram_raddr;
        end else if (i_cmd.alloc_step) begin
            r_addr <= {r_next_free[FRAME_W-1:0], level_index(r_vpn, n_lvl)};
        end
        if (i_cmd.set_result) begin
            r_found   <= ram_rdata[0];
            r_ppn_res <= ram_rdata[0] ? ram_rdata[ENTRY_W-1:1] : '0;
            r_oof     <= r_update && !r_erase && !ram_rdata[0] && !o_status.fits;
        end
        if (i_cmd.push_out) begin
            r_out_found <= r_found;
            r_out_ppn   <= r_ppn_res;
            r_out_oof   <= r_oof;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_out_found;
    assign o_ppn_out       = r_out_ppn;
    assign o_out_of_frames = r_out_oof;

endmodule

FILE: hw/rtl/ptw_ctrl.sv
module ptw_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ptw_pkg::t_ptw_status i_status,
    output ptw_pkg::t_ptw_cmd    o_cmd
);
    import ptw_pkg::*;

    t_ptw_state r_state;
    t_ptw_state n_state;

    logic map_req;
    logic unmap_req;

    assign map_req   = i_status.is_update && !i_status.is_erase;
    assign unmap_req = i_status.is_update && i_status.is_erase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_status.item_in) n_state = ST_READ;
            end
            ST_READ: n_state = ST_EVAL;
            ST_EVAL: begin
                if (i_status.entry_valid && !i_status.last_level) begin
                    n_state = ST_READ;
                end else if (map_req && !i_status.entry_valid && i_status.fits &&
                             !i_status.last_level) begin
                    n_state = ST_ALLOC;
                end else begin
                    n_state = ST_FINISH;
                end
            end
            ST_ALLOC: begin
                if (i_status.alloc_last) n_state = ST_LEAF;
            end
            ST_LEAF: n_state = ST_FINISH;
            ST_FINISH: begin
                if (!i_status.out_busy) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '{default: '0, wr_sel: WR_NONE};
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                o_cmd.wr_sel   = WR_CLEAR;
            end
            ST_IDLE: o_cmd.ready = 1'b1;
            ST_READ: o_cmd.rd = 1'b1;
            ST_EVAL: begin
                if (i_status.entry_valid && !i_status.last_level) begin
                    o_cmd.step_down = 1'b1;
                end else begin
                    o_cmd.set_result = 1'b1;
                    if (i_status.entry_valid && unmap_req) begin
                        o_cmd.wr_sel = WR_UNMAP;
                    end else if (i_status.entry_valid && map_req) begin
                        o_cmd.wr_sel = WR_LEAF;
                    end else if (map_req && i_status.fits && i_status.last_level) begin
                        o_cmd.wr_sel = WR_LEAF;
                    end
                end
            end
            ST_ALLOC: begin
                o_cmd.alloc_step = 1'b1;
                o_cmd.wr_sel     = WR_LINK;
            end
            ST_LEAF: o_cmd.wr_sel = WR_LEAF;
            ST_FINISH: o_cmd.push_out = !i_status.out_busy;
            default: o_cmd.ready = 1'b0;
        endcase
    end

endmodule

FILE: bench/five_level_page_table_walker_tb.sv
`timescale 1ns / 100ps

module five_level_page_table_walker_tb;

    import ptw_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int MAX_WAIT       = 17;
    localparam int PHASES         = 10;
    localparam int ITEMS_PER_PHASE = 123;
    localparam int POOL_DEPTH     = 48;
    localparam int SETTLE_CYCLES  = 20;

    localparam logic [PPN_W-1:0] MAX_PPN = '1;
    localparam logic [PPN_W-1:0] PPN_5S  = 52'h5_5555_5555_5555;
    localparam logic [PPN_W-1:0] PPN_AS  = 52'hA_AAAA_AAAA_AAAA;
    localparam logic [PPN_W-1:0] PPN_F0  = 52'hF_0F0F_0F0F_0F0F;

    typedef enum logic { CMD_QUERY = 1'b0, CMD_UPDATE = 1'b1 } t_cmd;
    typedef enum logic { OP_MAP = 1'b0, OP_UNMAP = 1'b1 } t_upd_op;
    typedef enum logic { ROW_REQUEST, ROW_REG_WRITE } t_row_kind;

    typedef struct packed {
        logic             found;
        logic [PPN_W-1:0] ppn;
        logic             out_of_frames;
    } t_walk_resp;

    // One line of the directed table: either a request or a register write.
    typedef struct packed {
        t_row_kind              kind;
        t_cmd                   cmd;
        logic [VPN_W-1:0]       vpn;
        t_upd_op                op;
        logic [PPN_W-1:0]       ppn;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_W-1:0]       reg_val;
        logic                   typed;
        t_walk_resp             resp;
    } t_dir_row;

    // DUT inputs start at known values
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 i_command   = 1'b0;
    logic [VPN_W-1:0]     i_vpn       = '0;
    logic                 i_erase     = 1'b0;
    logic [PPN_W-1:0]     i_ppn       = '0;
    logic                 i_stall     = 1'b0;

    logic                 o_stall;
    logic                 o_valid;
    logic                 o_found;
    logic [PPN_W-1:0]     o_ppn_out;
    logic                 o_out_of_frames;

    // Shadow page table: node store, root pointer and frame allocator
    logic [ENTRY_W-1:0]   page_mem [STORE_DEPTH];
    logic [ROOT_W-1:0]    root_node;
    int unsigned          alloc_next;

    t_walk_resp           resp_fifo [$];
    logic [VPN_W-1:0]     vpn_pool  [$];

    int          mismatches = 0;
    int unsigned next_gap   = 1;
    int unsigned stall_left = 0;
    bit          send_idle  = 1'b1;
    bit          stall_idle = 1'b1;

    five_level_page_table_walker u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_command       (i_command),
        .i_vpn           (i_vpn),
        .i_erase         (i_erase),
        .i_ppn           (i_ppn),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_ppn_out       (o_ppn_out),
        .o_out_of_frames (o_out_of_frames)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Hard stop in case a handshake never completes.
    initial begin
        #7_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Index bits of one level, top level first.
    function automatic logic [INDEX_BITS-1:0] vpn_slice(input logic [VPN_W-1:0] vpn,
                                                        input int lvl);
        return INDEX_BITS'(vpn >> (INDEX_BITS * (LEVELS - 1 - lvl)));
    endfunction

    // Node address: the frame number wraps modulo the node count.
    function automatic logic [STORE_AW-1:0] slot_of(input logic [PPN_W-1:0] frame,
                                                    input logic [INDEX_BITS-1:0] idx);
        return {frame[FRAME_W-1:0], idx};
    endfunction

    function automatic logic [VPN_W-1:0] vpn_of(input int a, input int b, input int c,
                                                input int d, input int e);
        return {INDEX_BITS'(a), INDEX_BITS'(b), INDEX_BITS'(c), INDEX_BITS'(d),
                INDEX_BITS'(e)};
    endfunction

    // Walk the shadow table, report the leaf as it was, then apply the update.
    function automatic t_walk_resp walk_table(input t_cmd cmd, input logic [VPN_W-1:0] vpn,
                                              input t_upd_op op,
                                              input logic [PPN_W-1:0] ppn);
        t_walk_resp          r;
        logic [PPN_W-1:0]    frame;
        logic [STORE_AW-1:0] slot;
        logic [ENTRY_W-1:0]  ent;
        int                  lvl;
        int unsigned         need;
        int unsigned         f;
        r     = '0;
        frame = PPN_W'(root_node);
        slot  = '0;
        for (lvl = 0; lvl < LEVELS; lvl++) begin
            slot = slot_of(frame, vpn_slice(vpn, lvl));
            ent  = page_mem[slot];
            if (!ent[0]) break;
            if (lvl == LEVELS - 1) begin
                r.found = 1'b1;
                r.ppn   = ent[ENTRY_W-1:1];
                break;
            end
            frame = ent[ENTRY_W-1:1];
        end
        if (cmd == CMD_UPDATE) begin
            if (op == OP_UNMAP) begin
                if (r.found) page_mem[slot][0] = 1'b0;
            end else if (r.found) begin
                page_mem[slot] = {ppn, 1'b1};
            end else begin
                // build the missing inner nodes, or give up with nothing touched
                need = LEVELS - 1 - lvl;
                if (alloc_next + need > NODE_FRAMES) begin
                    r.out_of_frames = 1'b1;
                end else begin
                    for (int l = lvl; l < LEVELS - 1; l++) begin
                        f = alloc_next;
                        alloc_next++;
                        page_mem[slot] = {PPN_W'(f), 1'b1};
                        slot = slot_of(PPN_W'(f), vpn_slice(vpn, l + 1));
                    end
                    page_mem[slot] = {ppn, 1'b1};
                end
            end
        end
        return r;
    endfunction

    function automatic t_dir_row req_row(input t_cmd cmd, input logic [VPN_W-1:0] vpn,
                                         input t_upd_op op, input logic [PPN_W-1:0] ppn,
                                         input logic typed, input logic found,
                                         input logic [PPN_W-1:0] ppn_out, input logic oof);
        t_dir_row row;
        row      = '0;
        row.kind = ROW_REQUEST;
        row.cmd  = cmd;
        row.vpn  = vpn;
        row.op   = op;
        row.ppn  = ppn;
        row.typed = typed;
        row.resp = '{found: found, ppn: ppn_out, out_of_frames: oof};
        return row;
    endfunction

    function automatic t_dir_row reg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        t_dir_row row;
        row         = '0;
        row.kind    = ROW_REG_WRITE;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Write one register; the shadow copy follows at the same edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_ROOT_FRAME) begin
            root_node = val[ROOT_W-1:0];
        end else begin
            alloc_next = 32'(val);
        end
        @(posedge i_clk);
    endtask

    // Present one request and hold it until taken. The gap before the next
    // request is drawn here, so valid only drops when a gap follows.
    task automatic send_request(input t_cmd cmd, input logic [VPN_W-1:0] vpn,
                                input t_upd_op op, input logic [PPN_W-1:0] ppn,
                                input logic typed, input t_walk_resp want);
        t_walk_resp pred;
        repeat (next_gap) @(posedge i_clk);
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_vpn     <= vpn;
        i_erase   <= op;
        i_ppn     <= ppn;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // accepted at this edge: predict in arrival order
        pred = walk_table(cmd, vpn, op, ppn);
        resp_fifo.push_back(typed ? want : pred);
        next_gap = send_idle ? $urandom_range(0, MAX_WAIT) : 0;
        if (next_gap != 0) i_valid <= 1'b0;
    endtask

    // Drop valid, wait for every response, then let the walker settle.
    task automatic quiesce();
        if (next_gap == 0) i_valid <= 1'b0;
        next_gap = 1;
        while (resp_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Response side: check each accepted response against the oldest
    // prediction, then draw how long to stall before the next one.
    always @(posedge i_clk) begin
        t_walk_resp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (resp_fifo.size() == 0) begin
                report_mismatch("response with no request pending", 64'(o_ppn_out), '0);
            end else begin
                want = resp_fifo.pop_front();
                if (o_found !== want.found)
                    report_mismatch("found", 64'(o_found), 64'(want.found));
                if (o_ppn_out !== want.ppn)
                    report_mismatch("ppn_out", 64'(o_ppn_out), 64'(want.ppn));
                if (o_out_of_frames !== want.out_of_frames)
                    report_mismatch("out_of_frames", 64'(o_out_of_frames),
                                    64'(want.out_of_frames));
            end
            stall_left = stall_idle ? $urandom_range(0, MAX_WAIT) : 0;
            i_stall <= (stall_left != 0);
        end else if (stall_left != 0) begin
            stall_left--;
            i_stall <= (stall_left != 0);
        end
    end

    initial begin
        t_dir_row         dir_tab [$];
        t_dir_row         row;
        logic [VPN_W-1:0] v;
        logic [VPN_W-1:0] base;
        logic [PPN_W-1:0] p;
        t_cmd             cmd;
        t_upd_op          op;
        int               pick;
        logic [CFG_W-1:0] root_val;
        logic [CFG_W-1:0] free_val;

        for (int a = 0; a < STORE_DEPTH; a++) page_mem[a] = '0;
        root_node  = '0;
        alloc_next = 32'(FIRST_FREE_RESET);

        // hold reset low before releasing it; the store sweep then runs with stall high
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Fresh table: nothing mapped, allocator at frame 1.
        dir_tab.push_back(req_row(CMD_QUERY, '0, OP_MAP, '0, 1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, '1, OP_UNMAP, MAX_PPN, 1'b1, 1'b0, '0, 1'b0));
        // build the full path for page zero, then rewrite, unmap, unmap again
        dir_tab.push_back(req_row(CMD_UPDATE, '0, OP_MAP, MAX_PPN, 1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, '0, OP_MAP, '0, 1'b1, 1'b1, MAX_PPN, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, '0, OP_MAP, '0, 1'b1, 1'b1, MAX_PPN, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, '0, OP_UNMAP, MAX_PPN, 1'b1, 1'b1, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, '0, OP_UNMAP, '0, 1'b1, 1'b1, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, '0, OP_UNMAP, '0, 1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, '1, OP_MAP, PPN_5S, 1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, '1, OP_MAP, '0, 1'b1, 1'b1, PPN_5S, 1'b0));
        // leaf node already there: map needs no new frame
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(0, 0, 0, 0, 1), OP_MAP, PPN_AS,
                                  1'b1, 1'b0, '0, 1'b0));
        // allocator exhausted: a new path fails, a leaf-only map still fits
        dir_tab.push_back(reg_row(CFG_FIRST_FREE, CFG_W'(NODE_FRAMES)));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(2, 0, 0, 0, 0), OP_MAP, 52'd1,
                                  1'b1, 1'b0, '0, 1'b1));
        dir_tab.push_back(req_row(CMD_QUERY, vpn_of(2, 0, 0, 0, 0), OP_MAP, '0,
                                  1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(0, 0, 0, 0, 2), OP_MAP, 52'd3,
                                  1'b1, 1'b0, '0, 1'b0));
        // two frames left: four do not fit, one does
        dir_tab.push_back(reg_row(CFG_FIRST_FREE, CFG_W'(NODE_FRAMES - 2)));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(3, 0, 0, 0, 0), OP_MAP, 52'd1,
                                  1'b1, 1'b0, '0, 1'b1));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(0, 0, 0, 5, 7), OP_MAP, PPN_F0,
                                  1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, vpn_of(0, 0, 0, 5, 7), OP_MAP, '0,
                                  1'b1, 1'b1, PPN_F0, 1'b0));
        // root at the last frame, never written
        dir_tab.push_back(reg_row(CFG_ROOT_FRAME, CFG_W'(NODE_FRAMES - 1)));
        dir_tab.push_back(req_row(CMD_QUERY, '0, OP_MAP, '0, 1'b1, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, '1, OP_MAP, PPN_5S, 1'b0, 1'b0, '0, 1'b0));
        // root on a leaf node: leaf frame numbers become wrapped node pointers
        dir_tab.push_back(reg_row(CFG_ROOT_FRAME, CFG_W'(4)));
        dir_tab.push_back(req_row(CMD_QUERY, vpn_of(1, 0, 0, 0, 0), OP_MAP, '0,
                                  1'b0, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_QUERY, vpn_of(2, 0, 0, 0, 1), OP_MAP, '0,
                                  1'b0, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(2, 0, 0, 0, 1), OP_MAP, PPN_AS,
                                  1'b0, 1'b0, '0, 1'b0));
        dir_tab.push_back(req_row(CMD_UPDATE, vpn_of(1, 2, 3, 4, 5), OP_UNMAP, '0,
                                  1'b0, 1'b0, '0, 1'b0));

        foreach (dir_tab[n]) begin
            row = dir_tab[n];
            if (row.kind == ROW_REG_WRITE) begin
                quiesce();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_request(row.cmd, row.vpn, row.op, row.ppn, row.typed, row.resp);
            end
        end

        // Random phases: reload root and allocator, then mostly revisit mapped
        // pages or their neighbors so walks get deep; the rest is fresh noise.
        for (int ph = 0; ph < PHASES; ph++) begin
            quiesce();
            if (ph == 0) begin
                // allocator starts on the root node itself
                root_val = '0;
                free_val = '0;
            end else if (ph == 1) begin
                root_val = CFG_W'(NODE_FRAMES - 1);
                free_val = CFG_W'(1);
            end else begin
                pick = $urandom_range(0, 3);
                root_val = (pick == 0) ? CFG_W'(0) :
                           (pick == 1) ? CFG_W'(NODE_FRAMES - 1) :
                                         CFG_W'($urandom_range(0, NODE_FRAMES - 1));
                pick = $urandom_range(0, 5);
                free_val = (pick == 0) ? CFG_W'(0) :
                           (pick == 1) ? CFG_W'(NODE_FRAMES) :
                                         CFG_W'($urandom_range(0, 40));
            end
            write_reg(CFG_ROOT_FRAME, root_val);
            write_reg(CFG_FIRST_FREE, free_val);

            // some phases run with one or both sides at full rate
            pick       = $urandom_range(0, 3);
            send_idle  = (pick & 1) != 0;
            stall_idle = (pick & 2) != 0;

            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 9);
                v    = VPN_W'({$urandom, $urandom});
                if (vpn_pool.size() != 0 && pick < 7) begin
                    base = vpn_pool[$urandom_range(0, vpn_pool.size() - 1)];
                    if (pick < 4) begin
                        v = base;
                    end else if (pick < 6) begin
                        v = {base[VPN_W-1:INDEX_BITS], v[INDEX_BITS-1:0]};
                    end else begin
                        v = {base[VPN_W-1:2*INDEX_BITS], v[2*INDEX_BITS-1:0]};
                    end
                end
                pick = $urandom_range(0, 9);
                cmd  = (pick < 4) ? CMD_QUERY : CMD_UPDATE;
                op   = (pick >= 8) ? OP_UNMAP : OP_MAP;
                // queries carry random erase and frame bits that must be ignored
                if (cmd == CMD_QUERY) op = t_upd_op'($urandom_range(0, 1));
                p = PPN_W'({$urandom, $urandom});
                send_request(cmd, v, op, p, 1'b0, '0);
                if (cmd == CMD_UPDATE && op == OP_MAP) begin
                    vpn_pool.push_back(v);
                    if (vpn_pool.size() > POOL_DEPTH) void'(vpn_pool.pop_front());
                end
            end
        end

        quiesce();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_ram.sv
hw/rtl/ptw_datapath.sv
hw/rtl/ptw_ctrl.sv
hw/rtl/five_level_page_table_walker.sv
bench/five_level_page_table_walker_tb.sv
